@@ rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

	localparam int DEPTH          = 16;
	localparam int TAG_WIDTH      = 16;
	localparam int PRIORITY_WIDTH = 4;
	localparam int CNT_WIDTH      = $clog2(DEPTH + 1);
	localparam int STATUS_WIDTH   = 2;

	// Command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// Status codes
	localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                      command;
		logic [TAG_WIDTH-1:0]      tag;
		logic [PRIORITY_WIDTH-1:0] priority_req;
	} in_t;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0]   status;
		logic [TAG_WIDTH-1:0]      out_tag;
		logic [PRIORITY_WIDTH-1:0] out_priority;
		logic [CNT_WIDTH-1:0]      occupancy;
		logic                      is_empty;
	} out_t;

	// One stored entry
	typedef struct packed {
		logic [TAG_WIDTH-1:0]      tag;
		logic [PRIORITY_WIDTH-1:0] prio;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ent;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
module spq_cell (
	input  wire logic               clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire logic               occupied,
	input  wire logic               left_goes_right,
	input  wire spq_pkg::entry_t    left_ent,
	input  wire spq_pkg::entry_t    right_ent,
	output logic                    goes_right,
	output spq_pkg::entry_t         ent
);
	import spq_pkg::*;

	entry_t ent_q;

	// New entry belongs somewhere to the right of this cell
	assign goes_right = occupied && (ent_q.prio < ctrl.ent.prio);
	assign ent        = ent_q;

	// Insert: keep, take new entry, or shift in from the left.
	// Remove: shift in from the right.
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!goes_right) begin
				if (left_goes_right) begin
					ent_q <= ctrl.ent;
				end else begin
					ent_q <= left_ent;
				end
			end
		end else if (ctrl.deq) begin
			ent_q <= right_ent;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
`default_nettype none
// Sorted priority queue built as a chain of DEPTH entry cells.
// Each input transaction's result is registered in the output register.
// Throughput: one transaction per cycle while results are taken; every cell
// compares and shifts in the same cycle, and the output register frees up as
// soon as it is taken. Reset clears the entry count and the output valid;
// cell contents are left as they are and are never read before being written.
module sorted_priority_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire spq_pkg::in_t   in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output spq_pkg::out_t       out_data
);
	import spq_pkg::*;

	logic [CNT_WIDTH-1:0] count_q;
	logic                 out_valid_q;
	out_t                 out_q;

	logic                 accept;
	logic                 is_full;
	logic                 is_void;
	cell_ctrl_t           ctrl;
	logic [DEPTH-1:0]     goes_right;
	entry_t               ents [DEPTH];
	out_t                 res_d;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_full   = (count_q == CNT_WIDTH'(DEPTH));
	assign is_void   = (count_q == '0);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Command decode broadcast to the chain
	always_comb begin
		ctrl.enq     = accept && (in_data.command == CMD_ENQUEUE) && !is_full;
		ctrl.deq     = accept && (in_data.command == CMD_DEQUEUE) && !is_void;
		ctrl.ent.tag  = in_data.tag;
		ctrl.ent.prio = in_data.priority_req;
	end

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   lgr;
		entry_t lent;
		entry_t rent;

		assign occ = (count_q > CNT_WIDTH'(i));
		if (i == 0) begin : g_first
			assign lgr  = 1'b1;
			assign lent = ents[0];
		end else begin : g_mid
			assign lgr  = goes_right[i-1];
			assign lent = ents[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rent = ents[i];
		end else begin : g_inner
			assign rent = ents[i+1];
		end

		spq_cell u_cell (
			.clk             (clk),
			.ctrl            (ctrl),
			.occupied        (occ),
			.left_goes_right (lgr),
			.left_ent        (lent),
			.right_ent       (rent),
			.goes_right      (goes_right[i]),
			.ent             (ents[i])
		);
	end

	// Entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.enq) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.deq) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result for the transaction being accepted
	always_comb begin
		res_d           = '0;
		res_d.status    = ST_OK;
		res_d.occupancy = count_q;
		res_d.is_empty  = is_void;
		if (in_data.command == CMD_ENQUEUE) begin
			if (is_full) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.occupancy = count_q + 1'b1;
				res_d.is_empty  = 1'b0;
			end
		end else begin
			if (is_void) begin
				res_d.status = ST_EMPTY;
			end else begin
				res_d.out_tag      = ents[0].tag;
				res_d.out_priority = ents[0].prio;
				res_d.occupancy    = count_q - 1'b1;
				res_d.is_empty     = (count_q == CNT_WIDTH'(1));
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res_d;
		end
	end

endmodule
`default_nettype wire

@@ verif/sorted_priority_queue_tb.sv @@
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 600;
	localparam int CHUNK_ITEMS = 40;

	// one row of the directed stimulus table
	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// typed expectation travels with the transaction on directed rows
	bit   directed_typed;
	out_t directed_want;

	// predictor state
	logic [TAG_WIDTH-1:0]      held_tag [DEPTH];
	logic [PRIORITY_WIDTH-1:0] held_prio [DEPTH];
	int                        held_count;

	out_t      awaited_results [$];
	step_row_t step_rows [$];

	int tx_gap_pct;
	int rx_hold_pct;
	int cycles;
	int errors;
	int results_seen;
	int n_enq, n_deq, n_full, n_empty;

	sorted_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				awaited_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_hold_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// sorted insert ahead of the first entry with priority >= new one; pop from head
	function automatic out_t serve_command(input in_t item);
		out_t res;
		int   pos;
		res = '0;
		res.status = ST_OK;
		if (item.command == CMD_ENQUEUE) begin
			if (held_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] < item.priority_req)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_tag[i]  = held_tag[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_tag[pos]  = item.tag;
				held_prio[pos] = item.priority_req;
				held_count++;
			end
		end else if (held_count == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.out_tag      = held_tag[0];
			res.out_priority = held_prio[0];
			for (int i = 0; i + 1 < held_count; i++) begin
				held_tag[i]  = held_tag[i+1];
				held_prio[i] = held_prio[i+1];
			end
			held_count--;
		end
		res.occupancy = held_count[CNT_WIDTH-1:0];
		res.is_empty  = (held_count == 0);
		return res;
	endfunction

	// result checking first, then prediction for a transaction taken at this edge
	always @(posedge clk) begin
		out_t want;
		out_t model;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %h", out_data));
				end else begin
					want = awaited_results.pop_front();
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							out_data.status, want.status));
					if (out_data.out_tag !== want.out_tag)
						report_mismatch($sformatf("out_tag got %h want %h",
							out_data.out_tag, want.out_tag));
					if (out_data.out_priority !== want.out_priority)
						report_mismatch($sformatf("out_priority got %0d want %0d",
							out_data.out_priority, want.out_priority));
					if (out_data.occupancy !== want.occupancy)
						report_mismatch($sformatf("occupancy got %0d want %0d",
							out_data.occupancy, want.occupancy));
					if (out_data.is_empty !== want.is_empty)
						report_mismatch($sformatf("is_empty got %b want %b",
							out_data.is_empty, want.is_empty));
				end
			end
			if (in_valid && in_ready) begin
				model = serve_command(in_data);
				awaited_results.push_back(directed_typed ? directed_want : model);
				if (model.status == ST_FULL)
					n_full++;
				else if (model.status == ST_EMPTY)
					n_empty++;
				else if (in_data.command == CMD_ENQUEUE)
					n_enq++;
				else
					n_deq++;
			end
		end
	end

	function automatic in_t mk_in(input logic cmd, input logic [TAG_WIDTH-1:0] tag,
		input logic [PRIORITY_WIDTH-1:0] pri);
		in_t v;
		v.command      = cmd;
		v.tag          = tag;
		v.priority_req = pri;
		return v;
	endfunction

	function automatic out_t mk_out(input logic [STATUS_WIDTH-1:0] st,
		input logic [TAG_WIDTH-1:0] tag, input logic [PRIORITY_WIDTH-1:0] pri,
		input int occ);
		out_t v;
		v.status       = st;
		v.out_tag      = tag;
		v.out_priority = pri;
		v.occupancy    = occ[CNT_WIDTH-1:0];
		v.is_empty     = (occ == 0);
		return v;
	endfunction

	// present one transaction, with random idle cycles ahead of it
	task automatic send_command(input in_t item, input bit typed, input out_t want);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		in_data        <= item;
		directed_typed <= typed;
		directed_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	function automatic in_t random_command(input int enq_pct);
		in_t v;
		v.command      = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
		v.tag          = TAG_WIDTH'($urandom);
		// narrow priority range half the time to pile up ties
		v.priority_req = PRIORITY_WIDTH'($urandom_range(1) ? $urandom_range(3)
			: $urandom_range(15));
		return v;
	endfunction

	initial begin
		int bias;
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		directed_typed = 1'b0;
		directed_want  = '0;
		held_count     = 0;
		cycles         = 0;
		errors         = 0;
		results_seen   = 0;
		n_enq          = 0;
		n_deq          = 0;
		n_full         = 0;
		n_empty        = 0;
		tx_gap_pct     = 22;
		rx_hold_pct    = 75;

		// directed table: empty, extremes, tie order, fill, reject on full
		step_rows.push_back('{mk_in(CMD_DEQUEUE, 16'hFFFF, 4'hF), 1'b1,
			mk_out(ST_EMPTY, '0, '0, 0)});
		step_rows.push_back('{mk_in(CMD_ENQUEUE, 16'hFFFF, 4'hF), 1'b1,
			mk_out(ST_OK, '0, '0, 1)});
		step_rows.push_back('{mk_in(CMD_ENQUEUE, 16'h0000, 4'h0), 1'b1,
			mk_out(ST_OK, '0, '0, 2)});
		step_rows.push_back('{mk_in(CMD_ENQUEUE, 16'h1234, 4'h0), 1'b1,
			mk_out(ST_OK, '0, '0, 3)});
		step_rows.push_back('{mk_in(CMD_DEQUEUE, 16'h0000, 4'h0), 1'b1,
			mk_out(ST_OK, 16'h1234, 4'h0, 2)});
		step_rows.push_back('{mk_in(CMD_DEQUEUE, 16'hFFFF, 4'hF), 1'b1,
			mk_out(ST_OK, 16'h0000, 4'h0, 1)});
		step_rows.push_back('{mk_in(CMD_DEQUEUE, 16'h0000, 4'h0), 1'b1,
			mk_out(ST_OK, 16'hFFFF, 4'hF, 0)});
		step_rows.push_back('{mk_in(CMD_DEQUEUE, 16'h0000, 4'h0), 1'b1,
			mk_out(ST_EMPTY, '0, '0, 0)});
		for (int i = 0; i < DEPTH; i++)
			step_rows.push_back('{mk_in(CMD_ENQUEUE, TAG_WIDTH'(16'hA5A0 ^ (i << 8) ^ i),
				PRIORITY_WIDTH'(((i * 5) % 16) & 4'hC)), 1'b0, '0});
		step_rows.push_back('{mk_in(CMD_ENQUEUE, 16'h5A5A, 4'h3), 1'b1,
			mk_out(ST_FULL, '0, '0, DEPTH)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (step_rows[r])
			send_command(step_rows[r].item, step_rows[r].typed, step_rows[r].want);
		drain_results();

		// random phases: receiver-heavy idling, sender-heavy idling, none
		for (int phase = 0; phase < 3; phase++) begin
			tx_gap_pct  = (phase == 0) ? 22 : (phase == 1) ? 75 : 0;
			rx_hold_pct = (phase == 0) ? 75 : (phase == 1) ? 22 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// runs biased toward filling, draining or churning
				if (n % CHUNK_ITEMS == 0)
					bias = ($urandom_range(2) == 0) ? 15 : ($urandom_range(1) ? 50 : 85);
				send_command(random_command(bias), 1'b0, '0);
			end
			drain_results();
		end

		repeat (4) @(posedge clk);
		$display("covered %0d enqueues, %0d dequeues, %0d rejects on full, %0d empty dequeues",
			n_enq, n_deq, n_full, n_empty);
		$display("%0d results checked in %0d cycles, %0d errors", results_seen, cycles, errors);
		if (errors == 0 && awaited_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
